FILE: hw/rtl/dnscw_pkg.sv
`default_nettype none

package dnscw_pkg;

  // request codes carried in tuser
  localparam logic [2:0] FUNC_APPEND = 3'd0;
  localparam logic [2:0] FUNC_NAME   = 3'd1;
  localparam logic [2:0] FUNC_FINISH = 3'd2;
  localparam logic [2:0] FUNC_READ   = 3'd3;
  localparam logic [2:0] FUNC_CLEAR  = 3'd4;

  // configuration register indexes
  localparam logic [0:0] CFG_CANONICAL = 1'b0;
  localparam logic [0:0] CFG_LOWER     = 1'b1;

  localparam int unsigned MAX_PTR     = 16384;
  localparam logic [7:0]  PTR_TAG     = 8'hc0;
  localparam logic [15:0] PTR_BASE    = 16'hc000;
  localparam int unsigned MAX_PENDING = 256;
  localparam int unsigned MAX_NLABELS = 128;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  data_byte;
    logic        want;
    logic [11:0] read_address;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [12:0] packet_length;
    logic [13:0] pointer_offset;
    logic [7:0]  match_length;
    logic [7:0]  bytes_written;
    logic        compressed;
    logic        overflow;
  } res_t;

  function automatic logic [7:0] fold(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5a) begin
      r = b + 8'd32;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/dnscw_cmp.sv
`default_nettype none

// Shared byte compare unit: optional ASCII case fold on both sides.
module dnscw_cmp (
  input  wire logic [7:0] a_i,
  input  wire logic [7:0] b_i,
  input  wire logic       fold_i,
  output logic            eq_o,
  output logic [7:0]      a_out_o
);

  logic [7:0] fa;
  logic [7:0] fb;

  assign fa      = fold_i ? dnscw_pkg::fold(a_i) : a_i;
  assign fb      = fold_i ? dnscw_pkg::fold(b_i) : b_i;
  assign eq_o    = (fa == fb);
  assign a_out_o = fa;

endmodule

`default_nettype wire

FILE: hw/rtl/dnscw_seq.sv
`default_nettype none

module dnscw_seq #(
  parameter int PACKET_BYTES = 4096,
  parameter int NAME_SLOTS   = 64,
  parameter int MAX_LABELS   = 34
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start_i,
  input  wire dnscw_pkg::req_t req_i,
  input  wire logic            canonical_i,
  input  wire logic            lower_i,
  output logic                 busy_o,
  output logic                 done_o,
  output dnscw_pkg::res_t      res_o
);

  localparam int AW  = $clog2(PACKET_BYTES);
  localparam int FW  = $clog2(PACKET_BYTES + 1);
  localparam int PW  = $clog2(PACKET_BYTES + 66);
  localparam int SW  = $clog2(NAME_SLOTS);
  localparam int CW  = $clog2(NAME_SLOTS + 1);
  localparam int LW  = $clog2(MAX_LABELS);
  localparam int LCW = $clog2(MAX_LABELS + 1);

  typedef enum logic [21:0] {
    S_IDLE    = 22'h000001,
    S_READ    = 22'h000002,
    S_P_RD    = 22'h000004,
    S_P_EV    = 22'h000008,
    S_SL_RD   = 22'h000010,
    S_SL_EV   = 22'h000020,
    S_W_RD    = 22'h000040,
    S_W_EV    = 22'h000080,
    S_W_PT    = 22'h000100,
    S_C_INIT  = 22'h000200,
    S_C_RD    = 22'h000400,
    S_C_IDX   = 22'h000800,
    S_C_LEV   = 22'h001000,
    S_C_BRD   = 22'h002000,
    S_C_BEV   = 22'h004000,
    S_C_END   = 22'h008000,
    S_RESOLVE = 22'h010000,
    S_WR_RD   = 22'h020000,
    S_WR_EV   = 22'h040000,
    S_PTR_HI  = 22'h080000,
    S_PTR_LO  = 22'h100000,
    S_DONE    = 22'h200000
  } state_t;

  // memories
  logic [7:0]    store_mem [PACKET_BYTES];
  logic [7:0]    pend_mem  [dnscw_pkg::MAX_PENDING];
  logic [13:0]   slot_mem  [NAME_SLOTS];
  logic [7:0]    nv_mem    [MAX_LABELS];
  logic [AW-1:0] pv_mem    [MAX_LABELS];

  logic          st_we;
  logic [AW-1:0] st_wa, st_ra;
  logic [7:0]    st_wd, st_rd;
  logic          pd_we;
  logic [7:0]    pd_wa, pd_ra, pd_wd, pd_rd;
  logic          sl_we;
  logic [SW-1:0] sl_wa, sl_ra;
  logic [13:0]   sl_wd, sl_rd;
  logic          nv_we;
  logic [LW-1:0] nv_wa, nv_ra;
  logic [7:0]    nv_wd, nv_rd;
  logic          pv_we;
  logic [LW-1:0] pv_wa, pv_ra;
  logic [AW-1:0] pv_wd, pv_rd;

  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_wa] <= st_wd;
    end
    st_rd <= store_mem[st_ra];
  end

  always_ff @(posedge clk) begin
    if (pd_we) begin
      pend_mem[pd_wa] <= pd_wd;
    end
    pd_rd <= pend_mem[pd_ra];
  end

  always_ff @(posedge clk) begin
    if (sl_we) begin
      slot_mem[sl_wa] <= sl_wd;
    end
    sl_rd <= slot_mem[sl_ra];
  end

  always_ff @(posedge clk) begin
    if (nv_we) begin
      nv_mem[nv_wa] <= nv_wd;
    end
    nv_rd <= nv_mem[nv_ra];
  end

  always_ff @(posedge clk) begin
    if (pv_we) begin
      pv_mem[pv_wa] <= pv_wd;
    end
    pv_rd <= pv_mem[pv_ra];
  end

  // shared compare unit
  logic [7:0] cmp_a, cmp_b, cmp_fa;
  logic       cmp_fold, cmp_eq;

  dnscw_cmp u_cmp (
    .a_i     (cmp_a),
    .b_i     (cmp_b),
    .fold_i  (cmp_fold),
    .eq_o    (cmp_eq),
    .a_out_o (cmp_fa)
  );

  state_t         state_r, state_nxt;
  logic [2:0]     func_r, func_nxt;
  logic [FW-1:0]  fill_r, fill_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [8:0]     plen_r, plen_nxt;
  logic           drop_r, drop_nxt;
  logic           want_r, want_nxt;
  logic [7:0]     rdata_r, rdata_nxt;
  logic [8:0]     ppos_r, ppos_nxt;
  logic [7:0]     ncnt_r, ncnt_nxt;
  logic [8:0]     len_r, len_nxt;
  logic [CW-1:0]  slot_r, slot_nxt;
  logic [PW-1:0]  pos_r, pos_nxt;
  logic [LCW-1:0] pcnt_r, pcnt_nxt;
  logic [5:0]     ctag_r, ctag_nxt;
  logic [LCW-1:0] i_r, i_nxt;
  logic [LCW-1:0] j_r, j_nxt;
  logic [8:0]     cm_r, cm_nxt;
  logic           any_r, any_nxt;
  logic [AW-1:0]  last_r, last_nxt;
  logic [8:0]     mlen_r, mlen_nxt;
  logic [AW-1:0]  best_r, best_nxt;
  logic [7:0]     no_r, no_nxt;
  logic [AW-1:0]  po_r, po_nxt;
  logic [5:0]     nl_r, nl_nxt;
  logic [5:0]     k_r, k_nxt;
  logic [8:0]     wk_r, wk_nxt;
  logic [8:0]     wend_r, wend_nxt;
  logic           ptrm_r, ptrm_nxt;
  logic [8:0]     wcnt_r, wcnt_nxt;
  logic           comp_r, comp_nxt;

  logic       put_en, rec_en;
  logic [7:0] put_val;
  logic [8:0] cm_sum;
  logic [13:0] tgt;

  assign cm_sum = cm_r + 9'(nl_r) + 9'd1;
  assign tgt    = {ctag_r, st_rd};

  always_comb begin
    state_nxt = state_r;
    func_nxt  = func_r;
    fill_nxt  = fill_r;
    cnt_nxt   = cnt_r;
    plen_nxt  = plen_r;
    drop_nxt  = drop_r;
    want_nxt  = want_r;
    rdata_nxt = rdata_r;
    ppos_nxt  = ppos_r;
    ncnt_nxt  = ncnt_r;
    len_nxt   = len_r;
    slot_nxt  = slot_r;
    pos_nxt   = pos_r;
    pcnt_nxt  = pcnt_r;
    ctag_nxt  = ctag_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    cm_nxt    = cm_r;
    any_nxt   = any_r;
    last_nxt  = last_r;
    mlen_nxt  = mlen_r;
    best_nxt  = best_r;
    no_nxt    = no_r;
    po_nxt    = po_r;
    nl_nxt    = nl_r;
    k_nxt     = k_r;
    wk_nxt    = wk_r;
    wend_nxt  = wend_r;
    ptrm_nxt  = ptrm_r;
    wcnt_nxt  = wcnt_r;
    comp_nxt  = comp_r;

    put_en  = 1'b0;
    put_val = 8'd0;
    rec_en  = 1'b0;

    st_we = 1'b0;
    st_wa = fill_r[AW-1:0];
    st_wd = put_val;
    st_ra = po_r;
    pd_we = 1'b0;
    pd_wa = plen_r[7:0];
    pd_wd = req_i.data_byte;
    pd_ra = ppos_r[7:0];
    sl_we = 1'b0;
    sl_wa = cnt_r[SW-1:0];
    sl_wd = 14'(fill_r);
    sl_ra = slot_r[SW-1:0];
    nv_we = 1'b0;
    nv_wa = ncnt_r[LW-1:0];
    nv_wd = ppos_r[7:0];
    nv_ra = LW'(i_r - LCW'(1));
    pv_we = 1'b0;
    pv_wa = pcnt_r[LW-1:0];
    pv_wd = AW'(pos_r);
    pv_ra = LW'(j_r - LCW'(1));

    cmp_a    = pd_rd;
    cmp_b    = st_rd;
    cmp_fold = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (start_i) begin
          func_nxt  = req_i.func;
          want_nxt  = req_i.want;
          rdata_nxt = 8'd0;
          wcnt_nxt  = 9'd0;
          comp_nxt  = 1'b0;
          state_nxt = S_DONE;
          case (req_i.func)
            dnscw_pkg::FUNC_APPEND: begin
              put_en  = 1'b1;
              put_val = req_i.data_byte;
            end
            dnscw_pkg::FUNC_NAME: begin
              if (plen_r < 9'(dnscw_pkg::MAX_PENDING)) begin
                pd_we    = 1'b1;
                plen_nxt = plen_r + 9'd1;
              end
            end
            dnscw_pkg::FUNC_FINISH: begin
              ppos_nxt  = 9'd0;
              ncnt_nxt  = 8'd0;
              state_nxt = S_P_RD;
            end
            dnscw_pkg::FUNC_READ: begin
              if (32'(req_i.read_address) < 32'(fill_r)) begin
                st_ra     = AW'(req_i.read_address);
                state_nxt = S_READ;
              end
            end
            dnscw_pkg::FUNC_CLEAR: begin
              fill_nxt = '0;
              cnt_nxt  = '0;
              plen_nxt = 9'd0;
              drop_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end

      S_READ: begin
        rdata_nxt = st_rd;
        state_nxt = S_DONE;
      end

      // parse the pending name into label offsets
      S_P_RD: begin
        if (ppos_r >= plen_r) begin
          put_en    = 1'b1;
          state_nxt = S_DONE;
        end else begin
          pd_ra     = ppos_r[7:0];
          state_nxt = S_P_EV;
        end
      end

      S_P_EV: begin
        if (pd_rd == 8'd0) begin
          len_nxt = ppos_r + 9'd1;
          if (ppos_r + 9'd1 > 9'd255 || ncnt_r == 8'd0) begin
            put_en    = 1'b1;
            state_nxt = S_DONE;
          end else if (want_r && !canonical_i && !lower_i &&
                       ncnt_r <= 8'(MAX_LABELS)) begin
            slot_nxt  = '0;
            mlen_nxt  = 9'd0;
            best_nxt  = '0;
            state_nxt = S_SL_RD;
          end else begin
            rec_en    = 1'b1;
            wk_nxt    = 9'd0;
            wend_nxt  = ppos_r + 9'd1;
            ptrm_nxt  = 1'b0;
            state_nxt = S_WR_RD;
          end
        end else if (pd_rd > 8'd63 || ncnt_r >= 8'(dnscw_pkg::MAX_NLABELS)) begin
          put_en    = 1'b1;
          state_nxt = S_DONE;
        end else begin
          if (ncnt_r < 8'(MAX_LABELS)) begin
            nv_we = 1'b1;
          end
          ncnt_nxt  = ncnt_r + 8'd1;
          ppos_nxt  = ppos_r + 9'(pd_rd) + 9'd1;
          state_nxt = S_P_RD;
        end
      end

      // next recorded name position
      S_SL_RD: begin
        if (slot_r >= cnt_r) begin
          state_nxt = S_RESOLVE;
        end else begin
          sl_ra     = slot_r[SW-1:0];
          state_nxt = S_SL_EV;
        end
      end

      S_SL_EV: begin
        pos_nxt   = PW'(sl_rd);
        pcnt_nxt  = '0;
        state_nxt = S_W_RD;
      end

      // walk a stored name, following pointers
      S_W_RD: begin
        if (pos_r >= PW'(fill_r)) begin
          state_nxt = S_C_INIT;
        end else begin
          st_ra     = AW'(pos_r);
          state_nxt = S_W_EV;
        end
      end

      S_W_EV: begin
        if (st_rd[7:6] != 2'b00) begin
          if (pos_r + PW'(1) >= PW'(fill_r)) begin
            state_nxt = S_C_INIT;
          end else begin
            ctag_nxt  = st_rd[5:0];
            st_ra     = AW'(pos_r + PW'(1));
            state_nxt = S_W_PT;
          end
        end else if (st_rd == 8'd0) begin
          state_nxt = S_C_INIT;
        end else if (32'(pos_r) >= 32'(dnscw_pkg::MAX_PTR) ||
                     pos_r + PW'(st_rd) + PW'(1) > PW'(fill_r)) begin
          state_nxt = S_C_INIT;
        end else if (pcnt_r >= LCW'(MAX_LABELS)) begin
          slot_nxt  = slot_r + CW'(1);
          state_nxt = S_SL_RD;
        end else begin
          pv_we     = 1'b1;
          pcnt_nxt  = pcnt_r + LCW'(1);
          pos_nxt   = pos_r + PW'(st_rd) + PW'(1);
          state_nxt = S_W_RD;
        end
      end

      S_W_PT: begin
        if (32'(tgt) >= 32'(pos_r)) begin
          // pointer not strictly backwards: name unusable
          slot_nxt  = slot_r + CW'(1);
          state_nxt = S_SL_RD;
        end else begin
          pos_nxt   = PW'(tgt);
          state_nxt = S_W_RD;
        end
      end

      // compare labels from the back
      S_C_INIT: begin
        i_nxt     = LCW'(ncnt_r);
        j_nxt     = pcnt_r;
        cm_nxt    = 9'd1;
        any_nxt   = 1'b0;
        last_nxt  = '0;
        state_nxt = S_C_RD;
      end

      S_C_RD: begin
        if (i_r == '0 || j_r == '0) begin
          state_nxt = S_C_END;
        end else begin
          state_nxt = S_C_IDX;
        end
      end

      S_C_IDX: begin
        no_nxt    = nv_rd;
        po_nxt    = pv_rd;
        pd_ra     = nv_rd;
        st_ra     = pv_rd;
        state_nxt = S_C_LEV;
      end

      S_C_LEV: begin
        cmp_fold = 1'b0;
        if (!cmp_eq) begin
          state_nxt = S_C_END;
        end else begin
          nl_nxt    = pd_rd[5:0];
          k_nxt     = 6'd1;
          state_nxt = S_C_BRD;
        end
      end

      S_C_BRD: begin
        pd_ra     = no_r + 8'(k_r);
        st_ra     = po_r + AW'(k_r);
        state_nxt = S_C_BEV;
      end

      S_C_BEV: begin
        if (!cmp_eq) begin
          state_nxt = S_C_END;
        end else if (k_r == nl_r) begin
          if (cm_sum == len_r) begin
            // whole name found: stop searching
            mlen_nxt  = cm_sum;
            best_nxt  = po_r;
            state_nxt = S_RESOLVE;
          end else begin
            cm_nxt    = cm_sum;
            any_nxt   = 1'b1;
            last_nxt  = po_r;
            i_nxt     = i_r - LCW'(1);
            j_nxt     = j_r - LCW'(1);
            state_nxt = S_C_RD;
          end
        end else begin
          k_nxt     = k_r + 6'd1;
          state_nxt = S_C_BRD;
        end
      end

      S_C_END: begin
        if (any_r && mlen_r < cm_r) begin
          mlen_nxt = cm_r;
          best_nxt = last_r;
        end
        slot_nxt  = slot_r + CW'(1);
        state_nxt = S_SL_RD;
      end

      S_RESOLVE: begin
        wk_nxt = 9'd0;
        if (best_r != '0 && 32'(best_r) < 32'(dnscw_pkg::MAX_PTR)) begin
          if (mlen_r != len_r) begin
            rec_en = 1'b1;
          end
          wend_nxt = len_r - mlen_r;
          ptrm_nxt = 1'b1;
        end else begin
          rec_en   = 1'b1;
          wend_nxt = len_r;
          ptrm_nxt = 1'b0;
        end
        state_nxt = S_WR_RD;
      end

      S_WR_RD: begin
        if (wk_r >= wend_r) begin
          state_nxt = ptrm_r ? S_PTR_HI : S_DONE;
        end else begin
          pd_ra     = wk_r[7:0];
          state_nxt = S_WR_EV;
        end
      end

      S_WR_EV: begin
        cmp_fold  = lower_i;
        put_en    = 1'b1;
        put_val   = cmp_fa;
        wk_nxt    = wk_r + 9'd1;
        state_nxt = S_WR_RD;
      end

      S_PTR_HI: begin
        put_en    = 1'b1;
        put_val   = dnscw_pkg::PTR_TAG | {2'b00, 6'(best_r >> 8)};
        state_nxt = S_PTR_LO;
      end

      S_PTR_LO: begin
        put_en    = 1'b1;
        put_val   = best_r[7:0];
        comp_nxt  = 1'b1;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (func_r == dnscw_pkg::FUNC_FINISH) begin
          plen_nxt = 9'd0;
        end
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase

    // byte append into the packet store
    st_wd = put_val;
    if (put_en) begin
      if (fill_r < FW'(PACKET_BYTES)) begin
        st_we    = 1'b1;
        st_wa    = fill_r[AW-1:0];
        fill_nxt = fill_r + FW'(1);
        wcnt_nxt = wcnt_r + 9'd1;
      end else begin
        drop_nxt = 1'b1;
      end
    end

    // record a new name position
    if (rec_en && 32'(fill_r) < 32'(dnscw_pkg::MAX_PTR) &&
        cnt_r < CW'(NAME_SLOTS)) begin
      sl_we   = 1'b1;
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      cnt_r   <= '0;
      plen_r  <= 9'd0;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      cnt_r   <= cnt_nxt;
      plen_r  <= plen_nxt;
      drop_r  <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r  <= func_nxt;
    want_r  <= want_nxt;
    rdata_r <= rdata_nxt;
    ppos_r  <= ppos_nxt;
    ncnt_r  <= ncnt_nxt;
    len_r   <= len_nxt;
    slot_r  <= slot_nxt;
    pos_r   <= pos_nxt;
    pcnt_r  <= pcnt_nxt;
    ctag_r  <= ctag_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    cm_r    <= cm_nxt;
    any_r   <= any_nxt;
    last_r  <= last_nxt;
    mlen_r  <= mlen_nxt;
    best_r  <= best_nxt;
    no_r    <= no_nxt;
    po_r    <= po_nxt;
    nl_r    <= nl_nxt;
    k_r     <= k_nxt;
    wk_r    <= wk_nxt;
    wend_r  <= wend_nxt;
    ptrm_r  <= ptrm_nxt;
    wcnt_r  <= wcnt_nxt;
    comp_r  <= comp_nxt;
  end

  assign busy_o = (state_r != S_IDLE);
  assign done_o = (state_r == S_DONE);

  always_comb begin
    res_o.read_data      = rdata_r;
    res_o.packet_length  = 13'(fill_r);
    res_o.pointer_offset = comp_r ? 14'(best_r) : 14'd0;
    res_o.match_length   = comp_r ? mlen_r[7:0] : 8'd0;
    // only a finish reports its byte count
    res_o.bytes_written  = (func_r == dnscw_pkg::FUNC_FINISH) ? wcnt_r[7:0] : 8'd0;
    res_o.compressed     = comp_r;
    res_o.overflow       = drop_r;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dns_name_compression_writer.sv
`default_nettype none

// DNS name compression writer. Builds a packet in an internal byte store from raw
// byte requests and wire-format names loaded a byte at a time; on finish, when the
// request asks for compression and neither canonical nor lower mode is set, the name
// is matched case-insensitively against every recorded name position (pointers in
// the store are followed) and written as prefix plus pointer, or whole. Each request
// returns exactly one result; a new request is taken only once the previous result
// has been taken. A read inside the packet passes through an extra state to fetch
// the stored byte. A finish parses the pending name label by label, then for each
// recorded slot walks the stored name label by label and pointer by pointer,
// compares labels from the back byte by byte, and finally writes the name bytes and
// any pointer; the store has a single byte-wide read port, and one shared compare
// unit serves both the compares and the case fold on write.
module dns_name_compression_writer #(
  parameter int PACKET_BYTES = 4096,
  parameter int NAME_SLOTS   = 64,
  parameter int MAX_LABELS   = 34
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [7:0] data_byte, [8] caller_compress, [9] record_compress, [21:10] read_address
  input  wire logic [23:0] in_tdata,
  // [2:0] func
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] read_data, [20:8] packet_length, [34:21] pointer_offset,
  // [42:35] match_length, [50:43] bytes_written, [51] compressed, [52] overflow
  output logic [55:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [0:0]  cfg_wdata
);

  logic            canonical_r, lower_r;
  logic            out_valid_r;
  dnscw_pkg::res_t out_r;
  dnscw_pkg::req_t req;
  dnscw_pkg::res_t res;
  logic            busy, done, start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canonical_r <= 1'b0;
      lower_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        dnscw_pkg::CFG_CANONICAL: canonical_r <= cfg_wdata[0];
        dnscw_pkg::CFG_LOWER:     lower_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_tready = !busy && !out_valid_r;
  assign start     = in_tvalid && in_tready;

  always_comb begin
    req.func         = in_tuser;
    req.data_byte    = in_tdata[7:0];
    req.want         = in_tdata[8] & in_tdata[9];
    req.read_address = in_tdata[21:10];
  end

  dnscw_seq #(
    .PACKET_BYTES (PACKET_BYTES),
    .NAME_SLOTS   (NAME_SLOTS),
    .MAX_LABELS   (MAX_LABELS)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_i     (start),
    .req_i       (req),
    .canonical_i (canonical_r),
    .lower_i     (lower_r),
    .busy_o      (busy),
    .done_o      (done),
    .res_o       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r.overflow, out_r.compressed, out_r.bytes_written,
                       out_r.match_length, out_r.pointer_offset, out_r.packet_length,
                       out_r.read_data};

endmodule

`default_nettype wire
